// ===== design/rtt_pkg.sv =====
package rtt_pkg;

   localparam int RTT_BITS_DEF   = 40;
   localparam int COUNT_BITS_DEF = 32;
   localparam int SUM_BITS       = 64;
   localparam int QUEUE_DEPTH    = 2;

   typedef enum logic {
      FUNC_SENT  = 1'b0,
      FUNC_REPLY = 1'b1
   } func_type;

   typedef struct packed {
      logic        func;
      logic [39:0] rtt_ns;
   } req_type;

   typedef struct packed {
      logic [31:0] sent_total;
      logic [31:0] received_total;
      logic [6:0]  loss_percent;
      logic        stats_valid;
      logic [39:0] min_rtt;
      logic [39:0] max_rtt;
      logic [39:0] avg_rtt;
      logic [41:0] mdev_rtt;
   } rsp_type;

   // classified event handed from front to back
   typedef struct packed {
      logic        reply;
      logic [62:0] rtt;
   } evt_type;

endpackage

// ===== design/rtt_front.sv =====
module rtt_front #(
   parameter int RTT_BITS = rtt_pkg::RTT_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  rtt_pkg::req_type req_data,
   output logic            evt_valid,
   input  logic            evt_stall,
   output rtt_pkg::evt_type evt_data
);
   import rtt_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

   evt_type             queue_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   fill_ff, fill_in;
   logic                push, pop;
   evt_type             evt_in;
   logic [62:0]         rtt_masked;

   always_comb begin
      rtt_masked = '0;
      for (int i = 0; i < 40 && i < RTT_BITS; i++) begin
         rtt_masked[i] = req_data.rtt_ns[i];
      end
      evt_in.reply = (req_data.func == FUNC_REPLY);
      evt_in.rtt   = rtt_masked;
   end

   assign req_stall = (fill_ff == (PTR_BITS+1)'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign evt_valid = (fill_ff != '0);
   assign pop       = evt_valid && !evt_stall;
   assign evt_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= evt_in;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== design/rtt_divider.sv =====
module rtt_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient
);
   import rtt_pkg::*;

   logic [63:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] div_ff, div_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial, trial_diff;

   always_comb begin
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      div_in     = div_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      trial      = {rem_ff, quo_ff[63]};
      trial_diff = trial - {1'b0, div_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial_diff[32]) begin
            rem_in = trial_diff[31:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== design/rtt_back.sv =====
module rtt_back #(
   parameter int COUNT_BITS = rtt_pkg::COUNT_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             evt_valid,
   output logic             evt_stall,
   input  rtt_pkg::evt_type evt_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rtt_pkg::rsp_type rsp_data
);
   import rtt_pkg::*;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   // ceil(2^36 / 1000), exact for 26-bit partial dividends
   localparam logic [26:0] US_RECIP = 27'd68719477;

   typedef enum logic [3:0] {
      ST_IDLE, ST_US, ST_UPDATE, ST_SQUARE, ST_ACCUM, ST_LOSS, ST_DIV_US, ST_DIV_SQ,
      ST_DIV_NS, ST_VAR, ST_SQRT, ST_MDEV, ST_OUT
   } state_type;

   state_type             state_ff;
   logic [COUNT_BITS-1:0] sent_ff, recv_ff;
   logic [62:0]           low_ff, high_ff, rtt_ff;
   logic [63:0]           sum_ns_ff, sum_us_ff, sum_sq_ff;
   logic [63:0]           us_ff, sq_ff, avg_us_ff, mean_sq_ff, var_ff, root_ff, bit_ff;
   logic [6:0]            loss_ff;
   logic                  reply_ff, rsp_valid_ff;
   rsp_type               rsp_ff;
   logic [1:0]            us_idx_ff;
   logic                  us_phase_ff;
   logic [9:0]            us_rem_ff;
   logic [15:0]           us_q_ff;

   logic        div_start, div_done;
   logic [63:0] div_dividend, div_quotient;
   logic [31:0] div_divisor;
   logic [64:0] sum_ns_add, sum_us_add, sum_sq_add;
   logic [63:0] sq_mean, root_try;
   logic [31:0] sent32, recv32;
   logic [63:0] mdev_full;
   logic [63:0] rtt_wide;
   logic [15:0] us_digit;
   logic [25:0] us_part, us_back, us_diff;
   logic [52:0] us_prod;

   assign sent32 = 32'(sent_ff);
   assign recv32 = 32'(recv_ff);

   rtt_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      div_start    = 1'b0;
      div_dividend = sum_us_ff;
      div_divisor  = recv32;
      case (state_ff)
         ST_LOSS: begin
            div_start    = 1'b1;
            div_dividend = 64'(sent32 - recv32) * 64'd100;
            div_divisor  = sent32;
         end
         ST_DIV_US: begin
            div_start = div_done;
         end
         ST_DIV_SQ: begin
            div_start    = div_done;
            div_dividend = sum_sq_ff;
         end
         ST_DIV_NS: begin
            div_start    = div_done;
            div_dividend = sum_ns_ff;
         end
         default: ;
      endcase
   end

   // microseconds: 16-bit digits, quotient digit then remainder
   assign rtt_wide = {1'b0, rtt_ff};
   assign us_digit = rtt_wide[{us_idx_ff, 4'd0} +: 16];
   assign us_part  = {us_rem_ff, us_digit};
   assign us_prod  = {27'd0, us_part} * {26'd0, US_RECIP};
   assign us_back  = ({10'd0, us_q_ff} << 10) - ({10'd0, us_q_ff} << 5) +
                     ({10'd0, us_q_ff} << 3);
   assign us_diff  = us_part - us_back;

   assign sum_ns_add = {1'b0, sum_ns_ff} + 65'(rtt_ff);
   assign sum_us_add = {1'b0, sum_us_ff} + {1'b0, us_ff};
   assign sum_sq_add = {1'b0, sum_sq_ff} + {1'b0, sq_ff};

   assign sq_mean   = (avg_us_ff > 64'hFFFF_FFFF) ? '1 : avg_us_ff[31:0] * avg_us_ff[31:0];
   assign root_try  = root_ff + bit_ff;
   assign evt_stall = (state_ff != ST_IDLE);
   assign mdev_full = root_ff * 64'd1000;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sent_ff      <= '0;
         recv_ff      <= '0;
         low_ff       <= '0;
         high_ff      <= '0;
         sum_ns_ff    <= '0;
         sum_us_ff    <= '0;
         sum_sq_ff    <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (evt_valid) begin
                  reply_ff    <= evt_data.reply;
                  rtt_ff      <= evt_data.rtt;
                  us_ff       <= '0;
                  us_idx_ff   <= 2'd3;
                  us_phase_ff <= 1'b0;
                  us_rem_ff   <= '0;
                  state_ff    <= ST_US;
               end
            end
            ST_US: begin
               if (!us_phase_ff) begin
                  us_q_ff     <= us_prod[51:36];
                  us_phase_ff <= 1'b1;
               end else begin
                  us_rem_ff   <= us_diff[9:0];
                  us_ff       <= {us_ff[47:0], us_q_ff};
                  us_phase_ff <= 1'b0;
                  us_idx_ff   <= us_idx_ff - 1'b1;
                  if (us_idx_ff == 2'd0) state_ff <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               if (!reply_ff) begin
                  if (sent_ff != COUNT_MAX) sent_ff <= sent_ff + 1'b1;
                  state_ff <= ST_LOSS;
               end else begin
                  if (low_ff == '0 || rtt_ff < low_ff) low_ff <= rtt_ff;
                  if (rtt_ff > high_ff) high_ff <= rtt_ff;
                  if (recv_ff != COUNT_MAX) recv_ff <= recv_ff + 1'b1;
                  sum_ns_ff <= sum_ns_add[64] ? '1 : sum_ns_add[63:0];
                  sum_us_ff <= sum_us_add[64] ? '1 : sum_us_add[63:0];
                  state_ff <= ST_SQUARE;
               end
            end
            ST_SQUARE: begin
               sq_ff    <= (us_ff > 64'hFFFF_FFFF) ? '1 : us_ff[31:0] * us_ff[31:0];
               state_ff <= ST_ACCUM;
            end
            ST_ACCUM: begin
               sum_sq_ff <= sum_sq_add[64] ? '1 : sum_sq_add[63:0];
               state_ff  <= ST_LOSS;
            end
            ST_LOSS: begin
               state_ff <= ST_DIV_US;
            end
            ST_DIV_US: begin
               if (div_done) begin
                  loss_ff  <= (sent_ff != '0 && recv_ff <= sent_ff) ?
                              7'(div_quotient) : 7'd0;
                  state_ff <= ST_DIV_SQ;
               end
            end
            ST_DIV_SQ: begin
               if (div_done) begin
                  avg_us_ff <= div_quotient;
                  state_ff  <= ST_DIV_NS;
               end
            end
            ST_DIV_NS: begin
               if (div_done) begin
                  mean_sq_ff <= div_quotient;
                  state_ff   <= ST_VAR;
               end
            end
            ST_VAR: begin
               if (div_done) begin
                  rsp_ff.avg_rtt <= div_quotient[39:0];
                  var_ff   <= (mean_sq_ff >= sq_mean) ? mean_sq_ff - sq_mean : '0;
                  root_ff  <= '0;
                  bit_ff   <= 64'h4000_0000_0000_0000;
                  state_ff <= ST_SQRT;
               end
            end
            ST_SQRT: begin
               if (var_ff >= root_try) begin
                  var_ff  <= var_ff - root_try;
                  root_ff <= (root_ff >> 1) + bit_ff;
               end else begin
                  root_ff <= root_ff >> 1;
               end
               bit_ff <= bit_ff >> 2;
               if (bit_ff[0]) state_ff <= ST_MDEV;
            end
            ST_MDEV: begin
               rsp_ff.sent_total     <= sent32;
               rsp_ff.received_total <= recv32;
               rsp_ff.loss_percent   <= loss_ff;
               rsp_ff.stats_valid    <= (recv_ff != '0);
               rsp_ff.min_rtt        <= (recv_ff != '0) ? low_ff[39:0] : '0;
               rsp_ff.max_rtt        <= (recv_ff != '0) ? high_ff[39:0] : '0;
               rsp_ff.mdev_rtt       <= (recv_ff != '0) ? mdev_full[41:0] : '0;
               if (recv_ff == '0) rsp_ff.avg_rtt <= '0;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/rtt_latency_statistics_core.sv =====
// Each transaction goes through a microsecond conversion, four 64-step serial
// divisions (loss, mean, mean square, nanosecond average) and the 32-step
// square root before its result is offered.
// The back end takes no new transaction until the last result is accepted;
// a two-entry queue holds arrivals while the back end works.
// Reset clears all counters, sums, min and max, and empties the queue.
module rtt_latency_statistics_core #(
   parameter int RTT_BITS   = rtt_pkg::RTT_BITS_DEF,
   parameter int COUNT_BITS = rtt_pkg::COUNT_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rtt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rtt_pkg::rsp_type rsp_data
);
   import rtt_pkg::*;

   logic    evt_valid, evt_stall;
   evt_type evt_data;

   rtt_front #(.RTT_BITS(RTT_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .evt_valid (evt_valid),
      .evt_stall (evt_stall),
      .evt_data  (evt_data)
   );

   rtt_back #(.COUNT_BITS(COUNT_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .evt_valid (evt_valid),
      .evt_stall (evt_stall),
      .evt_data  (evt_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
